/* hdl/ses_pkg.sv */
// Shared constants and a helper function of the spectrum energy sampler.
`timescale 1ns / 1ps
package ses_pkg;

  localparam int MAX_POINTS = 256;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int COUNT_W    = ADDR_W + 1;
  localparam int ENERGY_W   = 32;
  localparam int WEIGHT_W   = 16;
  localparam int FRAC_W     = 32;
  localparam int SUM_W      = 56;
  localparam int EW_W       = ENERGY_W + WEIGHT_W;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Square root of the interpolation radicand and the fraction divider.
  localparam int SQ_W       = 62;
  localparam int SQ_STEPS   = SQ_W / 2;
  localparam int SQ_CNT_W   = $clog2(SQ_STEPS + 1);
  localparam int DIV_N_W    = 63;
  localparam int DIV_D_W    = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W + 1);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] MODE_INVALID  = 2'd0;
  localparam logic [1:0] MODE_DISCRETE = 2'd1;
  localparam logic [1:0] MODE_HISTO    = 2'd2;
  localparam logic [1:0] MODE_INTERP   = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BADMODE = 2'd1;
  localparam logic [1:0] STATUS_SHORT   = 2'd2;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_MIN   = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  function automatic logic [ENERGY_W-1:0] ses_span(input logic [ENERGY_W-1:0] lo,
                                                   input logic [ENERGY_W-1:0] hi);
    return (hi > lo) ? hi - lo : '0;
  endfunction

endpackage

/* hdl/ses_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module ses_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ses_isqrt.sv */
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module ses_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ses_pkg::SQ_W-1:0]    radicand,
  output logic                        done,
  output logic [ses_pkg::SQ_STEPS-1:0] root
);
  import ses_pkg::*;

  logic [SQ_W-1:0]     rem;
  logic [SQ_W-1:0]     res;
  logic [SQ_W-1:0]     probe;
  logic [SQ_CNT_W-1:0] cnt;
  logic                busy;
  logic [SQ_W-1:0]     trial;

  assign trial = res + probe;
  assign root  = res[SQ_STEPS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == SQ_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= radicand;
      res   <= '0;
      probe <= SQ_W'(1) << (SQ_W - 2);
      cnt   <= SQ_CNT_W'(SQ_STEPS);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + probe;
      end else begin
        res <= res >> 1;
      end
      probe <= probe >> 2;
      cnt   <= cnt - SQ_CNT_W'(1);
    end
  end

endmodule

/* hdl/ses_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ses_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ses_pkg::DIV_N_W-1:0]  num,
  input  logic [ses_pkg::DIV_D_W-1:0]  den,
  output logic                         done,
  output logic [ses_pkg::DIV_N_W-1:0]  quo
);
  import ses_pkg::*;

  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   den_q;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W:0]     diff;

  assign shifted = {rem, quo[DIV_N_W-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_q <= den;
      quo   <= num;
      cnt   <= DIV_CNT_W'(DIV_N_W);
    end else if (busy) begin
      if (shifted >= {1'b0, den_q}) begin
        rem <= diff[DIV_D_W-1:0];
        quo <= {quo[DIV_N_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_D_W-1:0];
        quo <= {quo[DIV_N_W-2:0], 1'b0};
      end
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

endmodule

/* hdl/spectrum_energy_sampler_unit.sv */
// Top level of the spectrum energy sampler: control sequencer and point memories.
//
// Points are kept in two synchronous memories, one holding energy and weight and one holding
// the cumulative weight, whose contents are undefined until loaded. A load item passes
// through a read, a multiply and a write state before the block is idle again. A sample item
// with an invalid mode or too short a table goes straight to the result state. Otherwise the
// cumulative memory is scanned from the first entry at one entry per cycle and the selected
// point is fetched; discrete mode then gives its result, while histogram mode and an
// interpolated segment with equal end weights first place the energy within the segment. An
// interpolated segment with unequal end weights also runs set-up states, a bit-serial square
// root and a bit-serial division before that; a zero divisor skips the division. The block
// returns to idle and takes the next item as soon as the result is issued, even while that
// result still waits on the output; a second finished result then waits in the block and
// holds the input off until the first has been taken.
`timescale 1ns / 1ps
module spectrum_energy_sampler_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [ses_pkg::ADDR_W-1:0]     point_index,
  input  logic [ses_pkg::ENERGY_W-1:0]   point_energy,
  input  logic [ses_pkg::WEIGHT_W-1:0]   point_weight,
  input  logic [ses_pkg::FRAC_W-1:0]     rand_select,
  input  logic [ses_pkg::FRAC_W-1:0]     rand_place,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ses_pkg::ENERGY_W-1:0]   energy,
  output logic [1:0]                     status
);
  import ses_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_LD_RD  = 19'h00002,
    S_LD_MUL = 19'h00004,
    S_LD_WR  = 19'h00008,
    S_TG_A   = 19'h00010,
    S_TG_B   = 19'h00020,
    S_TG_C   = 19'h00040,
    S_SCAN   = 19'h00080,
    S_F0     = 19'h00100,
    S_F1     = 19'h00200,
    S_F2     = 19'h00400,
    S_LF_A   = 19'h00800,
    S_LF_B   = 19'h01000,
    S_LF_C   = 19'h02000,
    S_LF_SQ  = 19'h04000,
    S_LF_DIV = 19'h08000,
    S_PL_A   = 19'h10000,
    S_PL_B   = 19'h20000,
    S_RESULT = 19'h40000
  } state_t;

  state_t state;

  logic [1:0]          spectrum_mode;
  logic [ENERGY_W-1:0] min_energy;
  logic [COUNT_W-1:0]  point_count;

  logic [ADDR_W-1:0]   idx_q;
  logic [ENERGY_W-1:0] e_q;
  logic [WEIGHT_W-1:0] w_q;
  logic [FRAC_W-1:0]   rs_q;
  logic [FRAC_W-1:0]   rp_q;

  logic [SUM_W-1:0]    total;
  logic [SUM_W:0]      target;
  logic [63:0]         prod;
  logic [ADDR_W-1:0]   scan_idx;
  logic [ADDR_W-1:0]   rd_idx;
  logic                rd_vld;
  logic [ADDR_W-1:0]   k;
  logic [ADDR_W-1:0]   last;
  logic [ENERGY_W-1:0] ea;
  logic [WEIGHT_W-1:0] wa;
  logic [WEIGHT_W-1:0] wb;
  logic [ENERGY_W-1:0] plo;
  logic [ENERGY_W-1:0] phi;
  logic [FRAC_W-1:0]   frac;
  logic [48:0]         us;
  logic signed [50:0]  dq;
  logic [31:0]         w0sq;
  logic [ENERGY_W-1:0] res_energy;
  logic [1:0]          res_status;

  logic                ew_we;
  logic [ADDR_W-1:0]   ew_raddr;
  logic [EW_W-1:0]     ew_rdata;
  logic                cum_we;
  logic [ADDR_W-1:0]   cum_waddr;
  logic [SUM_W-1:0]    cum_rdata;

  logic [COUNT_W-1:0]  n_eff;
  logic                too_few;
  logic [ENERGY_W-1:0] rd_e;
  logic [WEIGHT_W-1:0] rd_w;
  logic [ENERGY_W-1:0] ld_lo;
  logic [WEIGHT_W:0]   ld_wsum;
  logic [48:0]         ld_prod2;
  logic [48:0]         ld_prod3;
  logic [SUM_W-1:0]    ld_base;
  logic [SUM_W:0]      ld_sum;
  logic [SUM_W-1:0]    ld_sat;
  logic [WEIGHT_W:0]   lf_s;
  logic signed [16:0]  lf_d;
  logic signed [33:0]  lf_q;
  logic signed [63:0]  lf_r;
  logic [SQ_W-1:0]     sq_in;
  logic                sq_start;
  logic                sq_done;
  logic [SQ_STEPS-1:0] sq_root;
  logic [DIV_D_W-1:0]  den;
  logic                div_start;
  logic                div_done;
  logic [DIV_N_W-1:0]  div_quo;
  logic                in_acc;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign n_eff   = (point_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : point_count;
  assign too_few = (n_eff == '0) || (spectrum_mode == MODE_INTERP && n_eff < COUNT_W'(2));

  assign rd_e = ew_rdata[EW_W-1:WEIGHT_W];
  assign rd_w = ew_rdata[WEIGHT_W-1:0];

  assign ld_lo    = (idx_q == '0) ? min_energy : rd_e;
  assign ld_wsum  = {1'b0, rd_w} + {1'b0, w_q};
  assign ld_prod2 = 49'(ses_span(ld_lo, e_q)) * 49'(w_q);
  assign ld_prod3 = 49'(ses_span(rd_e, e_q)) * 49'(ld_wsum);
  assign ld_base  = (idx_q == '0) ? '0 : total;
  assign ld_sum   = {1'b0, ld_base} + (SUM_W + 1)'(prod[48:0]);
  assign ld_sat   = (ld_sum > {1'b0, SUM_MAX}) ? SUM_MAX : ld_sum[SUM_W-1:0];

  assign lf_s  = {1'b0, wa} + {1'b0, wb};
  assign lf_d  = $signed({1'b0, wb}) - $signed({1'b0, wa});
  assign lf_q  = $signed({1'b0, prod[48:16]});
  assign lf_r  = $signed({4'b0, w0sq, 28'b0}) + (64'(dq) <<< 12);
  assign sq_in = lf_r[63] ? '0 : lf_r[SQ_W-1:0];
  assign den   = {2'b0, wa, 14'b0} + {1'b0, sq_root};

  assign sq_start  = (state == S_LF_C);
  assign div_start = (state == S_LF_SQ) && sq_done && (den != '0);

  assign ew_we     = (state == S_LD_WR);
  assign cum_we    = (state == S_LD_WR) && !(spectrum_mode == MODE_INTERP && idx_q == '0);
  assign cum_waddr = (spectrum_mode == MODE_INTERP) ? idx_q - ADDR_W'(1) : idx_q;

  always_comb begin
    unique case (state)
      S_LD_RD: ew_raddr = idx_q - ADDR_W'(1);
      S_F1:    ew_raddr = (spectrum_mode == MODE_HISTO) ? k - ADDR_W'(1) : k + ADDR_W'(1);
      default: ew_raddr = k;
    endcase
  end

  ses_ram #(.WIDTH(EW_W), .DEPTH(MAX_POINTS)) u_ew_ram (
    .clk   (clk),
    .we    (ew_we),
    .waddr (idx_q),
    .wdata ({e_q, w_q}),
    .raddr (ew_raddr),
    .rdata (ew_rdata)
  );

  ses_ram #(.WIDTH(SUM_W), .DEPTH(MAX_POINTS)) u_cum_ram (
    .clk   (clk),
    .we    (cum_we),
    .waddr (cum_waddr),
    .wdata (ld_sat),
    .raddr (scan_idx),
    .rdata (cum_rdata)
  );

  ses_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  ses_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({us, 14'b0}),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      spectrum_mode <= MODE_DISCRETE;
      min_energy    <= '0;
      point_count   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MODE:  spectrum_mode <= cfg_data[1:0];
        CFG_MIN:   min_energy    <= cfg_data;
        CFG_COUNT: point_count   <= cfg_data[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
    end else begin
      if (out_valid && out_ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (command == CMD_LOAD) begin
              state <= S_LD_RD;
            end else if (spectrum_mode == MODE_INVALID || too_few) begin
              state <= S_RESULT;
            end else begin
              state <= S_TG_A;
            end
          end
        end
        S_LD_RD:  state <= S_LD_MUL;
        S_LD_MUL: state <= S_LD_WR;
        S_LD_WR: begin
          total <= (spectrum_mode == MODE_INTERP && idx_q == '0) ? '0 : ld_sat;
          state <= S_IDLE;
        end
        S_TG_A: state <= S_TG_B;
        S_TG_B: state <= S_TG_C;
        S_TG_C: state <= S_SCAN;
        S_SCAN: begin
          if (rd_vld && (({1'b0, cum_rdata} > target) || rd_idx == last)) begin
            state <= S_F0;
          end
        end
        S_F0: state <= S_F1;
        S_F1: state <= S_F2;
        S_F2: begin
          case (spectrum_mode)
            MODE_HISTO:  state <= S_PL_A;
            MODE_INTERP: state <= (wa == rd_w) ? S_PL_A : S_LF_A;
            default:     state <= S_RESULT;
          endcase
        end
        S_LF_A: state <= S_LF_B;
        S_LF_B: state <= S_LF_C;
        S_LF_C: state <= S_LF_SQ;
        S_LF_SQ: begin
          if (sq_done) begin
            state <= (den == '0) ? S_PL_A : S_LF_DIV;
          end
        end
        S_LF_DIV: begin
          if (div_done) begin
            state <= S_PL_A;
          end
        end
        S_PL_A: state <= S_PL_B;
        S_PL_B: state <= S_RESULT;
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          idx_q      <= point_index;
          e_q        <= point_energy;
          w_q        <= point_weight;
          rs_q       <= rand_select;
          rp_q       <= rand_place;
          res_energy <= '0;
          last       <= (spectrum_mode == MODE_INTERP) ? ADDR_W'(n_eff - COUNT_W'(2))
                                                       : ADDR_W'(n_eff - COUNT_W'(1));
          if (spectrum_mode == MODE_INVALID) begin
            res_status <= STATUS_BADMODE;
          end else if (too_few) begin
            res_status <= STATUS_SHORT;
          end else begin
            res_status <= STATUS_OK;
          end
        end
      end
      S_LD_MUL: begin
        case (spectrum_mode)
          MODE_DISCRETE: prod <= 64'(w_q);
          MODE_HISTO:    prod <= 64'(ld_prod2);
          MODE_INTERP:   prod <= 64'(ld_prod3 >> 1);
          default:       prod <= '0;
        endcase
      end
      S_TG_A: prod <= 64'(56'(rs_q) * 56'(total[SUM_W-1:32]));
      S_TG_B: begin
        target <= {1'b0, prod[SUM_W-1:0]};
        prod   <= 64'(rs_q) * 64'(total[31:0]);
      end
      S_TG_C: begin
        target   <= target + (SUM_W + 1)'(prod[63:32]);
        scan_idx <= '0;
        rd_vld   <= 1'b0;
      end
      S_SCAN: begin
        rd_vld <= 1'b1;
        rd_idx <= scan_idx;
        if (scan_idx != last) begin
          scan_idx <= scan_idx + ADDR_W'(1);
        end
        if (rd_vld) begin
          if ({1'b0, cum_rdata} > target) begin
            k <= rd_idx;
          end else if (rd_idx == last) begin
            k <= last;
          end
        end
      end
      S_F1: begin
        ea <= rd_e;
        wa <= rd_w;
      end
      S_F2: begin
        wb         <= rd_w;
        res_energy <= ea;
        frac       <= rp_q;
        if (spectrum_mode == MODE_HISTO) begin
          plo <= (k == '0) ? min_energy : rd_e;
          phi <= ea;
        end else begin
          plo <= ea;
          phi <= rd_e;
        end
      end
      S_LF_A: prod <= 64'(49'(rp_q) * 49'(lf_s));
      S_LF_B: begin
        us   <= prod[48:0];
        dq   <= 51'(lf_d * lf_q);
        w0sq <= 32'(wa) * 32'(wa);
      end
      S_LF_SQ: begin
        if (sq_done && den == '0) begin
          frac <= '0;
        end
      end
      S_LF_DIV: begin
        if (div_done) begin
          frac <= (div_quo[DIV_N_W-1:FRAC_W] != '0) ? '1 : div_quo[FRAC_W-1:0];
        end
      end
      S_PL_A: prod <= 64'(ses_span(plo, phi)) * 64'(frac);
      S_PL_B: res_energy <= plo + prod[63:32];
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          energy <= res_energy;
          status <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule
